FILE: src/zdle_pkg.sv
// ----------------------------------------------------------------------------
// ZDLE subpacket receiver package
// Shared widths, character and status codes, command word and CRC-16 step.
// ----------------------------------------------------------------------------
package zdle_pkg;

  localparam int BYTE_W   = 8;
  localparam int EVENT_W  = 2;
  localparam int STATUS_W = 4;
  localparam int COUNT_W  = 12;
  localparam int CRC_W    = 16;

  localparam logic [COUNT_W-1:0] MAX_CAPACITY = 12'd2048;
  localparam logic [COUNT_W-1:0] CAP_RESET    = 12'd1025;

  // Depth of the command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

  // Receive event kinds
  localparam logic [EVENT_W-1:0] EV_BYTE    = 2'd0;
  localparam logic [EVENT_W-1:0] EV_TIMEOUT = 2'd1;

  // Characters
  localparam logic [BYTE_W-1:0] CH_ZDLE     = 8'h18;
  localparam logic [BYTE_W-1:0] CH_XON      = 8'h11;
  localparam logic [BYTE_W-1:0] CH_XOFF     = 8'h13;
  localparam logic [BYTE_W-1:0] CH_FEND_LO  = 8'h68;
  localparam logic [BYTE_W-1:0] CH_FEND_HI  = 8'h6b;
  localparam logic [BYTE_W-1:0] CH_A        = 8'h41;
  localparam logic [BYTE_W-1:0] CH_C        = 8'h43;
  localparam logic [BYTE_W-1:0] LOW7_MASK   = 8'h7f;
  localparam logic [BYTE_W-1:0] CTL_MASK    = 8'h60;
  localparam logic [BYTE_W-1:0] CTL_MATCH   = 8'h40;
  localparam logic [BYTE_W-1:0] CTL_FLIP    = 8'h40;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_RUNNING   = 4'd0;
  localparam logic [STATUS_W-1:0] ST_END_E     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_END_W     = 4'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_CRC   = 4'd5;
  localparam logic [STATUS_W-1:0] ST_CANCELLED = 4'd6;
  localparam logic [STATUS_W-1:0] ST_BAD_ESC   = 4'd7;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 4'd8;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 4'd9;
  localparam logic [STATUS_W-1:0] ST_RX_ERROR  = 4'd10;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,  // stored byte, CRC update (restart when done)
    CMD_CHECK = 2'd1,  // compare received CRC and end
    CMD_END   = 2'd2   // end with given status
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                 op;
    logic [BYTE_W-1:0]       value;
    logic [CRC_W-1:0]        sent_crc;
    logic [STATUS_W-1:0]     status;
    logic                    done;
    logic [COUNT_W-1:0]      count;
  } cmd_t;

  // One byte of CRC-16/XMODEM, MSB first
  function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: src/zdle_ifs.sv
// ----------------------------------------------------------------------------
// ZDLE subpacket receiver channels
// Valid/ready channels for receive events, results and the capacity register.
// ----------------------------------------------------------------------------
interface zdle_rx_if import zdle_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   rx_byte;
  logic [EVENT_W-1:0]  event_kind;

  modport source (output valid, rx_byte, event_kind, input ready);
  modport sink   (input valid, rx_byte, event_kind, output ready);
endinterface

interface zdle_res_if import zdle_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic                byte_valid;
  logic                block_done;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  stored_count;

  modport source (output valid, out_byte, byte_valid, block_done, status, stored_count,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, block_done, status, stored_count,
                  output ready);
endinterface

interface zdle_cfg_if import zdle_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] block_capacity;

  modport source (output valid, block_capacity, input ready);
  modport sink   (input valid, block_capacity, output ready);
endinterface

FILE: src/zdle_front.sv
// ----------------------------------------------------------------------------
// ZDLE front end
// Unescape received words, track subpacket phase and count, issue commands.
// ----------------------------------------------------------------------------
module zdle_front import zdle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  zdle_rx_if.sink    rx,
  zdle_cfg_if.sink   cfg,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  typedef enum logic [5:0] {
    PH_DATA       = 6'b000001,
    PH_DATA_ESC   = 6'b000010,
    PH_CRC_HI     = 6'b000100,
    PH_CRC_HI_ESC = 6'b001000,
    PH_CRC_LO     = 6'b010000,
    PH_CRC_LO_ESC = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    STG_DATA = 2'd0,
    STG_HI   = 2'd1,
    STG_LO   = 2'd2
  } stage_t;

  phase_t             phase, phase_next;
  logic [1:0]         cancel_run, cancel_run_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [BYTE_W-1:0]  crc_high_byte, crc_high_byte_next;
  logic [2:0]         end_kind, end_kind_next;
  logic [COUNT_W-1:0] capacity;
  logic [COUNT_W-1:0] cap_use;
  logic [COUNT_W-1:0] cnt_inc;

  logic               accept;
  logic               esc;
  stage_t             stg;
  logic               is_fend, is_abc, is_ctl;
  logic [BYTE_W-1:0]  dec_val;
  logic               take_en, take_fend;
  logic [BYTE_W-1:0]  take_val;
  logic               clear;

  assign rx.ready  = !q_full;
  assign cfg.ready = 1'b1;
  assign accept    = rx.valid && rx.ready;

  always_comb begin
    if (capacity == '0) begin
      cap_use = 12'd1;
    end else if (capacity > MAX_CAPACITY) begin
      cap_use = MAX_CAPACITY;
    end else begin
      cap_use = capacity;
    end
  end

  assign cnt_inc = byte_count + 12'd1;

  // Escape decode of the current byte
  assign is_fend = (rx.rx_byte >= CH_FEND_LO) && (rx.rx_byte <= CH_FEND_HI);
  assign is_abc  = (rx.rx_byte >= CH_A) && (rx.rx_byte <= CH_C);
  assign is_ctl  = (rx.rx_byte & CTL_MASK) == CTL_MATCH;
  assign dec_val = (is_fend || is_abc) ? rx.rx_byte : (rx.rx_byte ^ CTL_FLIP);

  always_comb begin
    case (phase)
      PH_DATA: begin
        esc = 1'b0; stg = STG_DATA;
      end
      PH_DATA_ESC: begin
        esc = 1'b1; stg = STG_DATA;
      end
      PH_CRC_HI: begin
        esc = 1'b0; stg = STG_HI;
      end
      PH_CRC_HI_ESC: begin
        esc = 1'b1; stg = STG_HI;
      end
      PH_CRC_LO: begin
        esc = 1'b0; stg = STG_LO;
      end
      PH_CRC_LO_ESC: begin
        esc = 1'b1; stg = STG_LO;
      end
      default: begin
        esc = 1'b0; stg = STG_DATA;
      end
    endcase
  end

  always_comb begin
    phase_next         = phase;
    cancel_run_next    = cancel_run;
    byte_count_next    = byte_count;
    crc_high_byte_next = crc_high_byte;
    end_kind_next      = end_kind;
    q_push             = 1'b0;
    q_cmd              = '0;
    q_cmd.op           = CMD_DATA;
    take_en            = 1'b0;
    take_fend          = 1'b0;
    take_val           = rx.rx_byte;
    clear              = 1'b0;

    if (accept) begin
      if (rx.event_kind == EV_TIMEOUT || rx.event_kind != EV_BYTE) begin
        q_push       = 1'b1;
        q_cmd.op     = CMD_END;
        q_cmd.status = (rx.event_kind == EV_TIMEOUT) ? ST_TIMEOUT : ST_RX_ERROR;
        q_cmd.count  = byte_count;
        clear        = 1'b1;
      end else if (esc) begin
        if (rx.rx_byte == CH_ZDLE) begin
          if (cancel_run == 2'd3) begin
            q_push       = 1'b1;
            q_cmd.op     = CMD_END;
            q_cmd.status = ST_CANCELLED;
            q_cmd.count  = byte_count;
            clear        = 1'b1;
          end else begin
            cancel_run_next = cancel_run + 2'd1;
          end
        end else if (!(is_fend || is_abc || is_ctl)) begin
          q_push       = 1'b1;
          q_cmd.op     = CMD_END;
          q_cmd.status = ST_BAD_ESC;
          q_cmd.count  = byte_count;
          clear        = 1'b1;
        end else begin
          cancel_run_next = 2'd0;
          take_en         = 1'b1;
          take_val        = dec_val;
          take_fend       = is_fend && (stg == STG_DATA);
        end
      end else if (((rx.rx_byte & LOW7_MASK) == CH_XON) ||
                   ((rx.rx_byte & LOW7_MASK) == CH_XOFF)) begin
        // drop flow control
      end else if (rx.rx_byte == CH_ZDLE) begin
        cancel_run_next = 2'd0;
        case (stg)
          STG_DATA: phase_next = PH_DATA_ESC;
          STG_HI:   phase_next = PH_CRC_HI_ESC;
          STG_LO:   phase_next = PH_CRC_LO_ESC;
          default:  phase_next = PH_DATA_ESC;
        endcase
      end else begin
        take_en = 1'b1;
      end
    end

    if (take_en) begin
      case (stg)
        STG_DATA: begin
          q_push          = 1'b1;
          q_cmd.op        = CMD_DATA;
          q_cmd.value     = take_val;
          q_cmd.count     = cnt_inc;
          q_cmd.status    = ST_RUNNING;
          byte_count_next = cnt_inc;
          if (take_fend) begin
            end_kind_next = 3'(take_val[1:0]) + 3'd1;
            phase_next    = PH_CRC_HI;
          end else if (cnt_inc >= cap_use) begin
            q_cmd.done   = 1'b1;
            q_cmd.status = ST_NO_SPACE;
            clear        = 1'b1;
          end else begin
            phase_next = PH_DATA;
          end
        end
        STG_HI: begin
          crc_high_byte_next = take_val;
          phase_next         = PH_CRC_LO;
        end
        STG_LO: begin
          q_push         = 1'b1;
          q_cmd.op       = CMD_CHECK;
          q_cmd.sent_crc = {crc_high_byte, take_val};
          q_cmd.status   = 4'(end_kind);
          q_cmd.count    = byte_count;
          clear          = 1'b1;
        end
        default: begin
          phase_next = PH_DATA;
        end
      endcase
    end

    if (clear) begin
      phase_next         = PH_DATA;
      cancel_run_next    = 2'd0;
      byte_count_next    = '0;
      crc_high_byte_next = '0;
      end_kind_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DATA;
      cancel_run    <= 2'd0;
      byte_count    <= '0;
      crc_high_byte <= '0;
      end_kind      <= '0;
      capacity      <= CAP_RESET;
    end else begin
      phase         <= phase_next;
      cancel_run    <= cancel_run_next;
      byte_count    <= byte_count_next;
      crc_high_byte <= crc_high_byte_next;
      end_kind      <= end_kind_next;
      if (cfg.valid && cfg.ready) begin
        capacity <= cfg.block_capacity;
      end
    end
  end

`ifndef ASSERT_OFF
  a_check_kind: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_cmd.op == CMD_CHECK) |-> (q_cmd.status >= ST_END_E && q_cmd.status <= ST_END_W))
    else $error("CRC check issued without a frame-end kind");

  a_event_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && rx.event_kind != EV_BYTE) |=> (phase == PH_DATA && byte_count == '0))
    else $error("timeout or error did not restart the subpacket");
`endif

endmodule

FILE: src/zdle_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ZDLE command queue
// Short FIFO of decoded commands between the front and back ends.
// ----------------------------------------------------------------------------
module zdle_cmd_fifo import zdle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t                 slots [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_PTR_W:0]   fill;

  assign full    = fill == (CMD_PTR_W+1)'(CMD_DEPTH);
  assign empty   = fill == '0;
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (full && !pop) |=> (fill == (CMD_PTR_W+1)'(CMD_DEPTH)) || !$past(push))
    else $error("command queue overflow");
`endif

endmodule

FILE: src/zdle_back.sv
// ----------------------------------------------------------------------------
// ZDLE back end
// Run the CRC over stored bytes, check the received CRC, register results.
// ----------------------------------------------------------------------------
module zdle_back import zdle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  zdle_res_if.source res
);

  logic [CRC_W-1:0]    crc_accum, crc_accum_next;
  logic [BYTE_W-1:0]   out_byte_next;
  logic                byte_valid_next;
  logic                block_done_next;
  logic [STATUS_W-1:0] status_next;

  assign q_pop = !q_empty && (!res.valid || res.ready);

  always_comb begin
    crc_accum_next  = crc_accum;
    out_byte_next   = '0;
    byte_valid_next = 1'b0;
    block_done_next = 1'b1;
    status_next     = q_cmd.status;
    case (q_cmd.op)
      CMD_DATA: begin
        crc_accum_next  = q_cmd.done ? '0 : crc16_update(crc_accum, q_cmd.value);
        out_byte_next   = q_cmd.value;
        byte_valid_next = 1'b1;
        block_done_next = q_cmd.done;
      end
      CMD_CHECK: begin
        crc_accum_next = '0;
        status_next    = (q_cmd.sent_crc == crc_accum) ? q_cmd.status : ST_BAD_CRC;
      end
      default: begin
        crc_accum_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum <= '0;
      res.valid <= 1'b0;
    end else begin
      if (q_pop) begin
        crc_accum <= crc_accum_next;
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res.out_byte     <= out_byte_next;
      res.byte_valid   <= byte_valid_next;
      res.block_done   <= block_done_next;
      res.status       <= status_next;
      res.stored_count <= q_cmd.count;
    end
  end

`ifndef ASSERT_OFF
  a_end_has_done: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.byte_valid) |-> res.block_done)
    else $error("end result without block_done");

  a_crc_restart: assert property (@(posedge clk) disable iff (rst)
    (q_pop && (q_cmd.op != CMD_DATA || q_cmd.done)) |=> (crc_accum == '0))
    else $error("CRC not cleared after subpacket end");
`endif

endmodule

FILE: src/zdle_data_subpacket_receiver.sv
// ----------------------------------------------------------------------------
// ZDLE data subpacket receiver
// Decode a ZDLE-escaped data subpacket and check its CRC-16 trailer.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one receive event per word: rx_byte with event_kind byte, or a
//         timeout or receive error event. Flow-control characters, ZDLE
//         and cancel characters are swallowed without a result word.
//   res : zero or one result word per received word: each stored data
//         byte or frame-end code; the subpacket's last word carries the status
//         (end ok, bad CRC, cancel, bad escape, out of space, timeout, error).
//   cfg : block_capacity write, taken at any cycle (ready tied high);
//         write it only while the block is idle.
// Path: an accepted input word is written into the command queue, and its
//   result word is then loaded from the queue into the result register.
// Throughput: one word per cycle on both sides while res is ready and the
//   queue has room; the CRC-16 byte update in the back end is combinational.
// A four-entry command queue splits the front end from the back end, and
//   the result register lets rx keep flowing while a result waits. When res
//   stalls, the queue fills and rx.ready drops once it holds four commands.
// Reset: the subpacket restarts in the data phase with a zero CRC and count;
//   block_capacity returns to 1025.
module zdle_data_subpacket_receiver import zdle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  zdle_rx_if.sink     rx,
  zdle_cfg_if.sink    cfg,
  zdle_res_if.source  res
);

  // Command queue between decode and CRC/result stages
  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  cmd_t q_pop_cmd;
  logic q_empty;

  // Front: unescape, phase tracking, byte count and capacity limit
  zdle_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_push_cmd)
  );

  zdle_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .empty    (q_empty)
  );

  // Back: CRC accumulate, CRC compare, registered result word
  zdle_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_cmd   (q_pop_cmd),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule
